// ----- rtl/stable_priority_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// stable priority queue - assertion macros
// shared property forms used by the checker of the queue unit
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the stable priority queue modules
// ----------------------------------------------------------------------------
package spq_pkg;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_DUP   = 3'd1,
      ST_FULL  = 3'd2,
      ST_EMPTY = 3'd3,
      ST_NULL  = 3'd4
   } status_type;

   typedef struct packed {
      logic [15:0]        item;
      logic signed [15:0] kind;
      logic signed [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic dup;   // stored handle equals the probe handle
      logic later; // stored entry leaves after the probe
   } cmp_res_type;

endpackage

// ----- rtl/stable_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// bounded priority queue held in ascending priority order, fifo among equals
// ----------------------------------------------------------------------------
// Use: drive req_* with start high; the request transfers at the clock edge
// where start is high and busy is low. req_func selects insert or remove.
// Every request returns exactly one result on rsp_*, shown for one cycle with
// rsp_strobe high; the receiver cannot hold it off and must take it then.
// A null-handle insert or an empty remove is answered from idle in the cycle
// after the transfer. A remove reads the held entries in order; the head goes
// to the result and the rest move down one place. Any other insert first
// scans all held entries for a duplicate and for the insert position P, the
// first entry that leaves after the new one, else the tail; a duplicate or a
// full insert is then refused, else the entries from P up move up one place,
// top entry first, and the new entry is written at P. busy is low again in
// the result cycle, so the next request can transfer at the edge that ends
// it; null-handle inserts and empty removes run one a cycle. The entries sit
// in one memory with one read and one write port; a scan reads one entry a
// cycle through the compare unit (duplicate and position), and the shift
// moves one entry a cycle. busy stays high through them to the result cycle.
// Reset clears the count and the sequencer; the memory is not cleared, since
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [15:0]        req_item_id,
   input  logic signed [15:0] req_kind,
   input  logic signed [15:0] req_prio,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_out_item,
   output logic signed [15:0] rsp_out_kind,
   output logic signed [15:0] rsp_out_prio,
   output logic [4:0]         rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_SCAN     = 4'b0010,
      S_SHIFT_DN = 4'b0100,
      S_SHIFT_UP = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic          found_ff, found_in;
   logic          dup_ff, dup_in;
   entry_type     new_ff, new_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   status_type    rsp_status_ff, rsp_status_in;
   entry_type     rsp_entry_ff, rsp_entry_in;
   logic [4:0]    rsp_count_ff, rsp_count_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type     rd_entry, wr_entry;
   cmp_res_type   cmp_res;
   logic [CW-1:0] idx_dec;
   logic [CW-1:0] occ_inc, occ_dec;

   spq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   spq_cmp u_cmp (
      .stored (rd_entry),
      .probe  (new_ff),
      .result (cmp_res)
   );

   assign idx_dec = idx_ff - CW'(1);
   assign occ_inc = occ_ff + CW'(1);
   assign occ_dec = occ_ff - CW'(1);

   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      found_in      = found_ff;
      dup_in        = dup_ff;
      new_in        = new_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = rd_entry;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_func == FUNC_INSERT) begin
                  if (req_item_id == 16'd0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_NULL;
                     rsp_entry_in  = '0;
                     rsp_count_in  = 5'(occ_ff);
                  end else begin
                     new_in.item = req_item_id;
                     new_in.kind = req_kind;
                     new_in.prio = req_prio;
                     idx_in      = '0;
                     found_in    = 1'b0;
                     dup_in      = 1'b0;
                     state_in    = S_SCAN;
                  end
               end else if (occ_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_EMPTY;
                  rsp_entry_in  = '0;
                  rsp_count_in  = 5'(occ_ff);
               end else begin
                  idx_in   = '0;
                  state_in = S_SHIFT_UP;
               end
            end
         end

         S_SCAN: begin
            // one read issued per cycle, compared when the data returns
            if (idx_ff < occ_ff) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff[AW-1:0];
               idx_in       = idx_ff + CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (cmp_res.dup) begin
                  dup_in = 1'b1;
               end
               if (cmp_res.later && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = CW'(pend_addr_ff);
               end
            end
            if (idx_ff == occ_ff && !pend_ff) begin
               if (dup_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_DUP;
                  rsp_entry_in  = '0;
                  rsp_count_in  = 5'(occ_ff);
                  state_in      = S_IDLE;
               end else if (occ_ff == CW'(CAPACITY)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_FULL;
                  rsp_entry_in  = '0;
                  rsp_count_in  = 5'(occ_ff);
                  state_in      = S_IDLE;
               end else begin
                  if (!found_ff) begin
                     pos_in = occ_ff;
                  end
                  idx_in   = occ_ff;
                  state_in = S_SHIFT_DN;
               end
            end
         end

         S_SHIFT_DN: begin
            // open a gap at the insert position, top entry first
            if (idx_ff > pos_ff) begin
               rd_en        = 1'b1;
               rd_addr      = idx_dec[AW-1:0];
               idx_in       = idx_dec;
               pend_in      = 1'b1;
               pend_addr_in = idx_dec[AW-1:0];
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pend_addr_ff + AW'(1);
            end
            if (idx_ff == pos_ff && !pend_ff) begin
               wr_en         = 1'b1;
               wr_addr       = pos_ff[AW-1:0];
               wr_entry      = new_ff;
               occ_in        = occ_inc;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_entry_in  = '0;
               rsp_count_in  = 5'(occ_inc);
               state_in      = S_IDLE;
            end
         end

         S_SHIFT_UP: begin
            // head goes to the result, the rest move down one place
            if (idx_ff < occ_ff) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff[AW-1:0];
               idx_in       = idx_ff + CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[AW-1:0];
            end
            if (pend_ff) begin
               if (pend_addr_ff == '0) begin
                  rsp_entry_in = rd_entry;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = pend_addr_ff - AW'(1);
               end
            end
            if (idx_ff == occ_ff && !pend_ff) begin
               occ_in        = occ_dec;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_count_in  = 5'(occ_dec);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         occ_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      pend_addr_ff  <= pend_addr_in;
      found_ff      <= found_in;
      dup_ff        <= dup_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_item = rsp_entry_ff.item;
   assign rsp_out_kind = rsp_entry_ff.kind;
   assign rsp_out_prio = rsp_entry_ff.prio;
   assign rsp_count    = rsp_count_ff;

endmodule

// ----- rtl/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram
// generic single write, single read port memory with registered read data
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/spq_cmp.sv -----
// ----------------------------------------------------------------------------
// spq_cmp
// compare unit: checks one stored entry against the entry being inserted
// ----------------------------------------------------------------------------
module spq_cmp
   import spq_pkg::*;
(
   input  entry_type   stored,
   input  entry_type   probe,
   output cmp_res_type result
);

   assign result.dup   = (stored.item == probe.item);
   assign result.later = ($signed(stored.prio) > $signed(probe.prio));

endmodule

// ----- rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks on the stable priority queue unit, bound to the top level
// ----------------------------------------------------------------------------
`include "stable_priority_queue_unit_defines.svh"

module spq_checker
   import spq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_out_item
);

   // an accepted transfer either answers at once or keeps the unit busy
   `SPQ_ASSERT_NXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe, "accepted request neither answered nor busy")

   // a result is only shown once the unit is free again
   `SPQ_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy, "result shown while busy")

   // finishing a long operation always delivers its result
   `SPQ_ASSERT_IMP(a_done_strobe, clock, reset, $fell(busy), rsp_strobe, "busy dropped without a result")

   // refused operations carry no handle
   `SPQ_ASSERT_IMP(a_refused_null, clock, reset, rsp_strobe && rsp_status != ST_OK, rsp_out_item == 16'd0, "refused result carries a handle")

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_status   (rsp_status),
   .rsp_out_item (rsp_out_item)
);
